// ===== sv/drld_pkg.sv =====
// Shared types and codes for the data run list decoder.
package drld_pkg;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_LENGTH = 2'd2;
    localparam logic [1:0] PH_DELTA  = 2'd3;

    localparam logic [1:0] EV_RUN     = 2'd0;
    localparam logic [1:0] EV_ZERO    = 2'd1;
    localparam logic [1:0] EV_LIMIT   = 2'd2;
    localparam logic [1:0] EV_INVALID = 2'd3;

    localparam logic [1:0] KIND_POSITIVE = 2'd0;
    localparam logic [1:0] KIND_SPARSE   = 2'd1;
    localparam logic [1:0] KIND_ZERO     = 2'd2;
    localparam logic [1:0] KIND_NEGATIVE = 2'd3;

    localparam logic [3:0] NIBBLE_MAX = 4'd8;
    localparam logic [10:0] POS_MAX   = 11'h7FF;

    typedef struct packed {
        logic [1:0]         event_res;
        logic [9:0]         run_number;
        logic [63:0]        run_clusters;
        logic signed [63:0] start_cluster;
        logic [1:0]         cluster_kind;
        logic [7:0]         header_value;
    } drld_res_t;

endpackage

// ===== sv/drld_core.sv =====
// Run list byte decoder: header decode, field accumulation and cluster tracking.
module drld_core #(
    parameter int REGION_MAX_BYTES = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          run_byte,
    input  logic                start_list,
    input  logic [10:0]         region_bytes,
    output logic                res_valid,
    output drld_pkg::drld_res_t res
);
    import drld_pkg::*;

    localparam logic [10:0] LIMIT_CAP =
        (REGION_MAX_BYTES > 2047) ? 11'h7FF : 11'(REGION_MAX_BYTES);

    logic [1:0]  phase_reg, phase_next;
    logic [10:0] pos_reg, pos_next;
    logic [10:0] limit_reg, limit_next;
    logic [3:0]  len_left_reg, len_left_next;
    logic [3:0]  dlt_left_reg, dlt_left_next;
    logic [63:0] len_acc_reg, len_acc_next;
    logic [63:0] dlt_acc_reg, dlt_acc_next;
    logic [63:0] prev_reg, prev_next;
    logic [9:0]  cnt_reg, cnt_next;
    logic [7:0]  hdr_reg, hdr_next;

    logic [1:0]  eff_phase;
    logic [10:0] eff_pos;
    logic [10:0] eff_limit;
    logic [63:0] eff_prev;
    logic [9:0]  eff_cnt;
    logic [10:0] region_sat;
    logic [10:0] pos_adv;
    logic [3:0]  b_ln;
    logic [3:0]  b_dn;
    logic [3:0]  h_ln;
    logic [3:0]  h_dn;
    logic [2:0]  len_idx;
    logic [2:0]  dlt_idx;
    logic [63:0] len_acc_ins;
    logic [63:0] dlt_acc_ins;
    logic [63:0] dlt_byte;
    logic [63:0] clus_sum;
    logic        finish;

    assign region_sat = (region_bytes > LIMIT_CAP) ? LIMIT_CAP : region_bytes;
    assign eff_phase  = start_list ? PH_HEADER : phase_reg;
    assign eff_pos    = start_list ? 11'd0 : pos_reg;
    assign eff_limit  = start_list ? region_sat : limit_reg;
    assign eff_prev   = start_list ? 64'd0 : prev_reg;
    assign eff_cnt    = start_list ? 10'd0 : cnt_reg;
    assign pos_adv    = (eff_pos == POS_MAX) ? eff_pos : eff_pos + 11'd1;

    assign b_ln = run_byte[3:0];
    assign b_dn = run_byte[7:4];
    assign h_ln = hdr_reg[3:0];
    assign h_dn = hdr_reg[7:4];

    assign len_idx     = 3'(h_ln - len_left_reg);
    assign dlt_idx     = 3'(h_dn - dlt_left_reg);
    assign len_acc_ins = len_acc_reg | (64'(run_byte) << {len_idx, 3'b000});
    // last delta byte is sign extended into the upper bytes
    assign dlt_byte    = (dlt_left_reg == 4'd1) ? {{56{run_byte[7]}}, run_byte}
                                                : 64'(run_byte);
    assign dlt_acc_ins = dlt_acc_reg | (dlt_byte << {dlt_idx, 3'b000});
    assign clus_sum    = eff_prev + dlt_acc_ins;

    always_comb
    begin
        phase_next    = eff_phase;
        pos_next      = eff_pos;
        limit_next    = eff_limit;
        len_left_next = len_left_reg;
        dlt_left_next = dlt_left_reg;
        len_acc_next  = len_acc_reg;
        dlt_acc_next  = dlt_acc_reg;
        prev_next     = eff_prev;
        cnt_next      = eff_cnt;
        hdr_next      = hdr_reg;
        finish        = 1'b0;
        res_valid     = 1'b0;
        res           = '0;
        res.header_value = run_byte;

        case (eff_phase)
            PH_HEADER:
            begin
                if (run_byte == 8'h00)
                begin
                    phase_next    = PH_IDLE;
                    res_valid     = 1'b1;
                    res.event_res = EV_ZERO;
                end
                else if (eff_pos >= eff_limit)
                begin
                    phase_next    = PH_IDLE;
                    res_valid     = 1'b1;
                    res.event_res = EV_LIMIT;
                end
                else if (b_ln == 4'd0 || b_ln > NIBBLE_MAX || b_dn > NIBBLE_MAX)
                begin
                    phase_next    = PH_IDLE;
                    res_valid     = 1'b1;
                    res.event_res = EV_INVALID;
                end
                else
                begin
                    hdr_next      = run_byte;
                    len_left_next = b_ln;
                    dlt_left_next = b_dn;
                    len_acc_next  = '0;
                    dlt_acc_next  = '0;
                    pos_next      = pos_adv;
                    phase_next    = PH_LENGTH;
                end
            end
            PH_LENGTH:
            begin
                pos_next      = pos_adv;
                len_acc_next  = len_acc_ins;
                len_left_next = len_left_reg - 4'd1;
                if (len_left_reg == 4'd1)
                begin
                    if (dlt_left_reg == 4'd0)
                        finish = 1'b1;
                    else
                        phase_next = PH_DELTA;
                end
            end
            PH_DELTA:
            begin
                pos_next      = pos_adv;
                dlt_acc_next  = dlt_acc_ins;
                dlt_left_next = dlt_left_reg - 4'd1;
                if (dlt_left_reg == 4'd1)
                    finish = 1'b1;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (finish)
        begin
            cnt_next          = eff_cnt + 10'd1;
            phase_next        = PH_HEADER;
            res_valid         = 1'b1;
            res.event_res     = EV_RUN;
            res.run_number    = cnt_next;
            res.run_clusters  = len_acc_next;
            res.header_value  = hdr_reg;
            if (h_dn == 4'd0)
            begin
                res.cluster_kind = KIND_SPARSE;
            end
            else
            begin
                prev_next         = clus_sum;
                res.start_cluster = clus_sum;
                if (clus_sum == 64'd0)
                    res.cluster_kind = KIND_ZERO;
                else if (clus_sum[63])
                    res.cluster_kind = KIND_NEGATIVE;
                else
                    res.cluster_kind = KIND_POSITIVE;
            end
        end

        if (!accept)
            res_valid = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            pos_reg      <= '0;
            limit_reg    <= '0;
            len_left_reg <= '0;
            dlt_left_reg <= '0;
            len_acc_reg  <= '0;
            dlt_acc_reg  <= '0;
            prev_reg     <= '0;
            cnt_reg      <= '0;
            hdr_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            limit_reg    <= limit_next;
            len_left_reg <= len_left_next;
            dlt_left_reg <= dlt_left_next;
            len_acc_reg  <= len_acc_next;
            dlt_acc_reg  <= dlt_acc_next;
            prev_reg     <= prev_next;
            cnt_reg      <= cnt_next;
            hdr_reg      <= hdr_next;
        end
    end

    a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.event_res != EV_RUN |=> phase_reg == PH_IDLE)
        else $error("list end did not idle the decoder");

    a_run_back_to_header: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.event_res == EV_RUN |=> phase_reg == PH_HEADER)
        else $error("finished run did not return to header");

    a_length_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LENGTH |-> len_left_reg != 4'd0)
        else $error("length phase with no bytes left");

    a_delta_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DELTA |-> dlt_left_reg != 4'd0 && hdr_reg[7:4] != 4'd0)
        else $error("delta phase with no delta bytes");

endmodule

// ===== sv/data_run_list_decoder_top.sv =====
// Data run list decoder top level with stream ports and output skid buffer.
// Decodes a run list one byte per word at one word per clock while s_tready
// is high. Each byte is decoded in the cycle it is accepted; its result is
// registered in the output register, or the skid register during a stall.
// This two-entry buffer lets the slave side keep accepting while one result
// waits, so a stalled master side backs up the slave side only once both hold.
module data_run_list_decoder_top #(
    parameter int REGION_MAX_BYTES = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // run_byte[7:0], region_bytes[18:8], zero pad
    input  logic         s_tuser,   // start_list
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata,   // run_number, run_clusters, start_cluster,
                                    // cluster_kind, header_value, zero pad
    output logic [1:0]   m_tuser    // event_res
);
    import drld_pkg::*;

    logic      accept;
    logic      res_valid;
    drld_res_t res;

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    drld_res_t out_reg, out_next;
    drld_res_t skid_reg;
    logic      out_free;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = m_tready || !out_valid_reg;

    drld_core #(
        .REGION_MAX_BYTES(REGION_MAX_BYTES)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .run_byte    (s_tdata[7:0]),
        .start_list  (s_tuser),
        .region_bytes(s_tdata[18:8]),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_next       = res;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (!out_free && res_valid)
            skid_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_res;
    assign m_tdata  = {4'd0, out_reg.header_value, out_reg.cluster_kind,
                       out_reg.start_cluster, out_reg.run_clusters, out_reg.run_number};

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready && res_valid |=> skid_valid_reg)
        else $error("result lost while output stalled");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && m_tready |=> out_valid_reg && !skid_valid_reg)
        else $error("skid entry not moved to output");

endmodule

// ===== sim/data_run_list_decoder_top_test.sv =====
// Self-checking stream testbench for the data run list decoder top level.
`timescale 1ns / 1ps

module data_run_list_decoder_top_test;
    import drld_pkg::*;

    localparam int REGION_MAX_BYTES = 1024;
    localparam int ITEM_TARGET      = 1750;

    typedef struct {
        logic [7:0]  run_byte;
        logic        start_list;
        logic [10:0] region_bytes;
    } list_word_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [23:0]  s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [151:0] m_tdata;
    logic [1:0]   m_tuser;

    list_word_t list_bytes[$];
    list_word_t next_word;
    drld_res_t  run_reports_due[$];

    // decoder state mirrored for prediction
    logic [1:0]  dec_phase = PH_IDLE;
    logic [10:0] byte_pos = '0;
    logic [10:0] pos_limit = '0;
    logic [3:0]  len_left = '0;
    logic [3:0]  dlt_left = '0;
    logic [63:0] len_acc = '0;
    logic [63:0] dlt_acc = '0;
    logic [63:0] cur_cluster = '0;
    logic [9:0]  run_cnt = '0;
    logic [7:0]  run_header = '0;

    bit          start_pending = 1'b0;
    logic [10:0] region_next = '0;
    int          lists_made = 0;
    int          words_taken = 0;
    int          total_words = 0;
    int          mismatches = 0;
    int          seen_by_event[4] = '{0, 0, 0, 0};

    data_run_list_decoder_top #(
        .REGION_MAX_BYTES(REGION_MAX_BYTES)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #5 clk = ~clk;

    task automatic close_run();
        drld_res_t r;
        int        dnum;
        r = '0;
        dnum = int'(run_header[7:4]);
        run_cnt = run_cnt + 10'd1;
        if (dnum == 0)
        begin
            r.cluster_kind = KIND_SPARSE;
        end
        else
        begin
            if (dnum < 8 && dlt_acc[8 * dnum - 1])
                dlt_acc = dlt_acc | (~64'd0 << (8 * dnum));
            cur_cluster = cur_cluster + dlt_acc;
            r.start_cluster = cur_cluster;
            if (cur_cluster == 64'd0)
                r.cluster_kind = KIND_ZERO;
            else if (cur_cluster[63])
                r.cluster_kind = KIND_NEGATIVE;
            else
                r.cluster_kind = KIND_POSITIVE;
        end
        r.event_res    = EV_RUN;
        r.run_number   = run_cnt;
        r.run_clusters = len_acc;
        r.header_value = run_header;
        run_reports_due.push_back(r);
        dec_phase = PH_HEADER;
    endtask

    task automatic decode_run_byte(input logic [7:0] b, input logic st,
                                   input logic [10:0] region);
        drld_res_t r;
        bit        list_end;
        int        idx;
        r = '0;
        list_end = 1'b0;
        if (st)
        begin
            cur_cluster = '0;
            run_cnt     = '0;
            byte_pos    = '0;
            pos_limit   = (region > REGION_MAX_BYTES) ? 11'(REGION_MAX_BYTES) : region;
            dec_phase   = PH_HEADER;
        end
        case (dec_phase)
            PH_HEADER:
            begin
                list_end = 1'b1;
                r.header_value = b;
                if (b == 8'h00)
                    r.event_res = EV_ZERO;
                else if (byte_pos >= pos_limit)
                    r.event_res = EV_LIMIT;
                else if (b[3:0] == 4'd0 || b[3:0] > NIBBLE_MAX || b[7:4] > NIBBLE_MAX)
                    r.event_res = EV_INVALID;
                else
                begin
                    list_end   = 1'b0;
                    run_header = b;
                    len_left   = b[3:0];
                    dlt_left   = b[7:4];
                    len_acc    = '0;
                    dlt_acc    = '0;
                    if (byte_pos != POS_MAX)
                        byte_pos = byte_pos + 11'd1;
                    dec_phase = PH_LENGTH;
                end
                if (list_end)
                begin
                    dec_phase = PH_IDLE;
                    run_reports_due.push_back(r);
                end
            end
            PH_LENGTH:
            begin
                if (byte_pos != POS_MAX)
                    byte_pos = byte_pos + 11'd1;
                idx = int'(run_header[3:0]) - int'(len_left);
                len_acc = len_acc | (64'(b) << (8 * idx));
                len_left = len_left - 4'd1;
                if (len_left == 4'd0)
                begin
                    if (dlt_left == 4'd0)
                        close_run();
                    else
                        dec_phase = PH_DELTA;
                end
            end
            PH_DELTA:
            begin
                if (byte_pos != POS_MAX)
                    byte_pos = byte_pos + 11'd1;
                idx = int'(run_header[7:4]) - int'(dlt_left);
                dlt_acc = dlt_acc | (64'(b) << (8 * idx));
                dlt_left = dlt_left - 4'd1;
                if (dlt_left == 4'd0)
                    close_run();
            end
            default: ;
        endcase
    endtask

    function automatic int gap_pct(input bit for_sender);
        int stage;
        stage = (total_words == 0) ? 0 : (words_taken * 3) / total_words;
        if (stage == 0)
            return for_sender ? 33 : 52;
        else if (stage == 1)
            return for_sender ? 52 : 33;
        return 0;
    endfunction

    function automatic logic [7:0] field_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] bad_header();
        case ($urandom_range(0, 2))
            0: return {4'($urandom_range(1, 15)), 4'h0};
            1: return {4'($urandom_range(0, 15)), 4'($urandom_range(9, 15))};
            default: return {4'($urandom_range(9, 15)), 4'($urandom_range(1, 8))};
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] b);
        list_word_t w;
        w.run_byte = b;
        if (start_pending)
        begin
            w.start_list   = 1'b1;
            w.region_bytes = region_next;
            start_pending  = 1'b0;
        end
        else
        begin
            w.start_list   = 1'b0;
            w.region_bytes = 11'($urandom_range(0, REGION_MAX_BYTES));
        end
        list_bytes.push_back(w);
    endtask

    task automatic begin_list(input int region);
        start_pending = 1'b1;
        region_next   = 11'(region);
        lists_made++;
    endtask

    // header plus the first keep bytes of its length and delta fields
    task automatic push_run(input int ln, input int dn, input int keep);
        push_byte({4'(dn), 4'(ln)});
        for (int i = 0; i < keep && i < ln + dn; i++)
            push_byte(field_byte());
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                decode_run_byte(s_tdata[7:0], s_tuser, s_tdata[18:8]);
                words_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (list_bytes.size() != 0 && $urandom_range(0, 99) >= gap_pct(1'b1))
                begin
                    next_word = list_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'd0, next_word.region_bytes, next_word.run_byte};
                    s_tuser  <= next_word.start_list;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_report();
        drld_res_t want;
        drld_res_t got;
        got.event_res     = m_tuser;
        got.run_number    = m_tdata[9:0];
        got.run_clusters  = m_tdata[73:10];
        got.start_cluster = m_tdata[137:74];
        got.cluster_kind  = m_tdata[139:138];
        got.header_value  = m_tdata[147:140];
        seen_by_event[got.event_res]++;
        if (run_reports_due.size() == 0)
        begin
            $display("%0t: unexpected result word, event %h header %h",
                     $time, got.event_res, got.header_value);
            mismatches++;
            return;
        end
        want = run_reports_due.pop_front();
        if (got.event_res !== want.event_res)
        begin
            $display("%0t: event_res expected %h actual %h", $time, want.event_res,
                     got.event_res);
            mismatches++;
        end
        if (got.run_number !== want.run_number)
        begin
            $display("%0t: run_number expected %h actual %h", $time, want.run_number,
                     got.run_number);
            mismatches++;
        end
        if (got.run_clusters !== want.run_clusters)
        begin
            $display("%0t: run_clusters expected %h actual %h", $time, want.run_clusters,
                     got.run_clusters);
            mismatches++;
        end
        if (got.start_cluster !== want.start_cluster)
        begin
            $display("%0t: start_cluster expected %h actual %h", $time,
                     want.start_cluster, got.start_cluster);
            mismatches++;
        end
        if (got.cluster_kind !== want.cluster_kind)
        begin
            $display("%0t: cluster_kind expected %h actual %h", $time, want.cluster_kind,
                     got.cluster_kind);
            mismatches++;
        end
        if (got.header_value !== want.header_value)
        begin
            $display("%0t: header_value expected %h actual %h", $time, want.header_value,
                     got.header_value);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_report();
            m_tready <= ($urandom_range(0, 99) >= gap_pct(1'b0));
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int ln;
        int dn;
        int region;

        // bytes before any list start are dropped
        push_byte(8'h31);

        begin_list(REGION_MAX_BYTES);
        push_byte(8'h11); push_byte(8'hFF); push_byte(8'h05);
        // delta back to cluster zero
        push_byte(8'h11); push_byte(8'h00); push_byte(8'hFB);
        // sparse run
        push_byte(8'h01); push_byte(8'h07);
        // negative cluster
        push_byte(8'h11); push_byte(8'h01); push_byte(8'h80);
        push_byte(8'h00);
        push_byte(8'h55);

        begin_list(0);
        push_byte(8'h11);
        begin_list(REGION_MAX_BYTES);
        push_byte(8'h09);
        begin_list(REGION_MAX_BYTES);
        push_byte(8'h10);
        begin_list(REGION_MAX_BYTES);
        push_byte(8'h91);

        // field bytes past the limit are still taken; zero header wins over limit
        begin_list(2);
        push_byte(8'h11); push_byte(8'hAA); push_byte(8'hBB); push_byte(8'h00);
        begin_list(2);
        push_byte(8'h11); push_byte(8'h01); push_byte(8'h02); push_byte(8'h21);

        // restart in the middle of a run
        begin_list(REGION_MAX_BYTES);
        push_byte(8'h18); push_byte(8'h01);
        begin_list(REGION_MAX_BYTES);
        push_byte(8'h00);

        while (list_bytes.size() < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0, 1: region = $urandom_range(0, 40);
                2: region = REGION_MAX_BYTES;
                default: region = $urandom_range(0, REGION_MAX_BYTES);
            endcase
            begin_list(region);
            repeat ($urandom_range(1, 8))
            begin
                ln = $urandom_range(1, 8);
                dn = $urandom_range(0, 8);
                push_run(ln, dn, ln + dn);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: push_byte(8'h00);
                4, 5: push_byte(bad_header());
                6:
                begin
                    ln = $urandom_range(1, 8);
                    dn = $urandom_range(0, 8);
                    push_run(ln, dn, $urandom_range(0, ln + dn - 1));
                end
                7:
                begin
                    repeat ($urandom_range(1, 4))
                        push_byte(8'($urandom_range(0, 255)));
                end
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 3))
                    push_byte(8'($urandom_range(0, 255)));
            end
        end
        total_words = list_bytes.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        wait (list_bytes.size() == 0 && !s_tvalid);
        wait (run_reports_due.size() == 0);
        repeat (10) @(posedge clk);

        $display("Fed %0d byte words over %0d lists under three flow-control stages.",
                 words_taken, lists_made);
        $display("Results: %0d runs, %0d zero ends, %0d limit ends, %0d invalid headers.",
                 seen_by_event[EV_RUN], seen_by_event[EV_ZERO], seen_by_event[EV_LIMIT],
                 seen_by_event[EV_INVALID]);
        if (mismatches == 0 && run_reports_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
